/* rtl/core/mpa_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and types of the max pooling unit with argmax switches
// no dependencies
package mpa_pkg;

  localparam int MAX_FRAME_WIDTH  = 64;
  localparam int MAX_FRAME_HEIGHT = 64;
  localparam int MAX_CHANNELS     = 16;
  localparam int MAX_WINDOW       = 8;
  localparam int SAMPLE_BITS      = 16;

  localparam int X_BITS    = $clog2(MAX_FRAME_WIDTH);
  localparam int Y_BITS    = $clog2(MAX_FRAME_HEIGHT);
  localparam int CH_BITS   = $clog2(MAX_CHANNELS);
  localparam int ADDR_BITS = CH_BITS + Y_BITS + X_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;

  localparam int SIZE_BITS     = 7;
  localparam int WIN_BITS      = 4;
  localparam int PAD_BITS      = 3;
  localparam int NCH_BITS      = 5;
  localparam int NUM_REGS      = 7;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 7;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_POOL = 2'd1,
    ACT_GRAD = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_WIDTH   = 3'd0,
    REG_WINDOW_HEIGHT  = 3'd1,
    REG_STRIDE_STEP    = 3'd2,
    REG_PAD_AMOUNT     = 3'd3,
    REG_FRAME_WIDTH    = 3'd4,
    REG_FRAME_HEIGHT   = 3'd5,
    REG_FRAME_CHANNELS = 3'd6
  } cfg_reg_t;

  // request to recompute one output dimension
  typedef struct packed {
    logic                 start;
    logic [SIZE_BITS-1:0] frame;
    logic [WIN_BITS-1:0]  win;
    logic [PAD_BITS-1:0]  pad;
    logic [WIN_BITS-1:0]  stride;
    logic [SIZE_BITS-1:0] limit;
  } sz_req_t;

endpackage

/* rtl/core/mpa_size_div.sv */
`timescale 1ns / 1ps
// output dimension: (frame + 2*pad - win + stride) / stride, zero if not positive,
// saturated at a limit; restoring divider, one quotient bit per cycle; uses mpa_pkg
module mpa_size_div
  import mpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sz_req_t              req,
  output logic                 busy,
  output logic [SIZE_BITS-1:0] size
);

  logic signed [SIZE_BITS+1:0] n_full;
  logic                        run_r;
  logic [2:0]                  cnt_r;
  logic [SIZE_BITS-1:0]        num_r;
  logic [SIZE_BITS-1:0]        quo_r;
  logic [WIN_BITS-1:0]         rem_r;
  logic [WIN_BITS-1:0]         den_r;
  logic [SIZE_BITS-1:0]        lim_r;
  logic [SIZE_BITS-1:0]        size_r;
  logic [WIN_BITS:0]           trial;
  logic                        fits;
  logic [SIZE_BITS-1:0]        quo_nxt;
  logic [WIN_BITS:0]           rem_sub;

  assign n_full = $signed({2'b00, req.frame})
                + $signed({(SIZE_BITS - PAD_BITS + 1)'(0), req.pad, 1'b0})
                - $signed({(SIZE_BITS - WIN_BITS + 2)'(0), req.win})
                + $signed({(SIZE_BITS - WIN_BITS + 2)'(0), req.stride});

  assign trial   = {rem_r, num_r[SIZE_BITS-1]};
  assign fits    = trial >= {1'b0, den_r};
  assign rem_sub = trial - {1'b0, den_r};
  assign quo_nxt = {quo_r[SIZE_BITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      size_r <= '0;
    end else if (req.start) begin
      if (n_full <= 0) begin
        run_r  <= 1'b0;
        size_r <= '0;
      end else begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end
    end else if (run_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'(SIZE_BITS - 1)) begin
        run_r  <= 1'b0;
        size_r <= (quo_nxt > lim_r) ? lim_r : quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= n_full[SIZE_BITS-1:0];
      quo_r <= '0;
      rem_r <= '0;
      den_r <= req.stride;
      lim_r <= req.limit;
    end else if (run_r) begin
      num_r <= {num_r[SIZE_BITS-2:0], 1'b0};
      quo_r <= quo_nxt;
      rem_r <= fits ? rem_sub[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
    end
  end

  assign busy = run_r;
  assign size = size_r;

endmodule

/* rtl/core/max_pool_2d_with_argmax_unit.sv */
`timescale 1ns / 1ps
// max pooling with argmax switches: a load is written to the frame store when accepted; a pool
// scans the window to a result, one frame store read per cycle
// one item at a time; a config write stalls input while the output sizes divide
// sync active-low reset clears control and config to defaults, sizes to zero; stores not cleared
// uses mpa_pkg and mpa_size_div
module max_pool_2d_with_argmax_unit
  import mpa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [X_BITS-1:0]             in_pos_x,
  input  logic [Y_BITS-1:0]             in_pos_y,
  input  logic [CH_BITS-1:0]            in_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_result_value,
  output logic [X_BITS-1:0]             out_winner_x,
  output logic [Y_BITS-1:0]             out_winner_y,
  output logic [CH_BITS-1:0]            out_result_channel,
  output logic [1:0]                    out_status
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_SPAN  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_GRAD  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  localparam int XO_BITS = 11;

  state_t state_r, state_nxt;

  // configuration
  logic [WIN_BITS-1:0]  win_w_r, win_h_r, stride_r;
  logic [PAD_BITS-1:0]  pad_r;
  logic [SIZE_BITS-1:0] fw_r, fh_r;
  logic [NCH_BITS-1:0]  nch_r;
  logic                 cfg_pend_r;

  logic [WIN_BITS-1:0]  ww_eff, wh_eff, s_eff;
  logic [SIZE_BITS-1:0] fw_eff, fh_eff;
  logic [NCH_BITS-1:0]  nch_eff;

  sz_req_t              col_req, row_req;
  logic                 col_busy, row_busy;
  logic [SIZE_BITS-1:0] out_cols, out_rows;

  // item and scan state
  logic                          accept;
  logic [1:0]                    act_r;
  logic [X_BITS-1:0]             px_r;
  logic [Y_BITS-1:0]             py_r;
  logic [CH_BITS-1:0]            ch_r;
  logic signed [SAMPLE_BITS-1:0] grad_r;
  logic signed [XO_BITS-1:0]     x0_r, y0_r;
  logic [2:0]                    fx_r, fy_r;
  logic                          rd_v_r;
  logic [X_BITS-1:0]             rd_x_r;
  logic [Y_BITS-1:0]             rd_y_r;
  logic                          found_r;
  logic signed [SAMPLE_BITS-1:0] best_r;
  logic [X_BITS-1:0]             bx_r;
  logic [Y_BITS-1:0]             by_r;

  logic signed [SAMPLE_BITS-1:0] res_value_r;
  logic [X_BITS-1:0]             res_x_r;
  logic [Y_BITS-1:0]             res_y_r;
  logic [1:0]                    res_status_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic [X_BITS-1:0]             out_x_r;
  logic [Y_BITS-1:0]             out_y_r;
  logic [CH_BITS-1:0]            out_ch_r;
  logic [1:0]                    out_status_r;

  // memories
  logic signed [SAMPLE_BITS-1:0] frame_mem [DEPTH];
  logic [X_BITS+Y_BITS-1:0]      switch_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] fm_rdata_r;
  logic [X_BITS+Y_BITS-1:0]      sw_rdata_r;
  logic                          fm_we, sw_we;
  logic [ADDR_BITS-1:0]          fm_waddr, fm_raddr, sw_addr;

  logic [9:0]                    xprod, yprod;
  logic signed [XO_BITS-1:0]     x0_nxt, y0_nxt, x_end, y_end, ox, oy;
  logic                          hits_x, hits_y, in_range, cell_in, take, last_fy, last_fx;
  logic                          out_free;

  // effective register values
  always_comb begin
    ww_eff  = (win_w_r == '0) ? 4'd1 : ((win_w_r > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : win_w_r);
    wh_eff  = (win_h_r == '0) ? 4'd1 : ((win_h_r > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : win_h_r);
    s_eff   = (stride_r == '0) ? 4'd1 : stride_r;
    fw_eff  = (fw_r > 7'(MAX_FRAME_WIDTH)) ? 7'(MAX_FRAME_WIDTH) : fw_r;
    fh_eff  = (fh_r > 7'(MAX_FRAME_HEIGHT)) ? 7'(MAX_FRAME_HEIGHT) : fh_r;
    nch_eff = (nch_r > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : nch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r    <= 4'd2;
      win_h_r    <= 4'd2;
      stride_r   <= 4'd2;
      pad_r      <= 3'd0;
      fw_r       <= 7'd64;
      fh_r       <= 7'd64;
      nch_r      <= 5'd16;
      cfg_pend_r <= 1'b0;
    end else begin
      cfg_pend_r <= cfg_we && (cfg_index < CFG_IDX_BITS'(NUM_REGS));
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_WIDTH:   win_w_r  <= cfg_wdata[WIN_BITS-1:0];
          REG_WINDOW_HEIGHT:  win_h_r  <= cfg_wdata[WIN_BITS-1:0];
          REG_STRIDE_STEP:    stride_r <= cfg_wdata[WIN_BITS-1:0];
          REG_PAD_AMOUNT:     pad_r    <= cfg_wdata[PAD_BITS-1:0];
          REG_FRAME_WIDTH:    fw_r     <= cfg_wdata[SIZE_BITS-1:0];
          REG_FRAME_HEIGHT:   fh_r     <= cfg_wdata[SIZE_BITS-1:0];
          REG_FRAME_CHANNELS: nch_r    <= cfg_wdata[NCH_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    col_req        = '0;
    col_req.start  = cfg_pend_r;
    col_req.frame  = fw_eff;
    col_req.win    = ww_eff;
    col_req.pad    = pad_r;
    col_req.stride = s_eff;
    col_req.limit  = 7'(MAX_FRAME_WIDTH);
    row_req        = '0;
    row_req.start  = cfg_pend_r;
    row_req.frame  = fh_eff;
    row_req.win    = wh_eff;
    row_req.pad    = pad_r;
    row_req.stride = s_eff;
    row_req.limit  = 7'(MAX_FRAME_HEIGHT);
  end

  mpa_size_div u_cols (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (col_req),
    .busy  (col_busy),
    .size  (out_cols)
  );

  mpa_size_div u_rows (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (row_req),
    .busy  (row_busy),
    .size  (out_rows)
  );

  assign in_stall = (state_r != S_IDLE) || cfg_pend_r || col_busy || row_busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // window geometry
  always_comb begin
    xprod    = px_r * s_eff;
    yprod    = py_r * s_eff;
    x0_nxt   = $signed({1'b0, xprod}) - $signed({8'b0, pad_r});
    y0_nxt   = $signed({1'b0, yprod}) - $signed({8'b0, pad_r});
    x_end    = x0_r + $signed({7'b0, ww_eff}) - 11'sd1;
    y_end    = y0_r + $signed({7'b0, wh_eff}) - 11'sd1;
    hits_x   = (fw_eff != '0) && (x0_r < $signed({4'b0, fw_eff})) && !x_end[XO_BITS-1];
    hits_y   = (fh_eff != '0) && (y0_r < $signed({4'b0, fh_eff})) && !y_end[XO_BITS-1];
    in_range = ({1'b0, px_r} < out_cols) && ({1'b0, py_r} < out_rows)
            && ({1'b0, ch_r} < nch_eff);
    ox       = x0_r + $signed({8'b0, fx_r});
    oy       = y0_r + $signed({8'b0, fy_r});
    cell_in  = !ox[XO_BITS-1] && (ox < $signed({4'b0, fw_eff}))
            && !oy[XO_BITS-1] && (oy < $signed({4'b0, fh_eff}));
    last_fy  = (fy_r == 3'(wh_eff - 4'd1));
    last_fx  = (fx_r == 3'(ww_eff - 4'd1));
    take     = rd_v_r && (!found_r || (fm_rdata_r > best_r));
  end

  assign fm_we    = accept && (in_action == ACT_LOAD);
  assign fm_waddr = {in_channel, in_pos_y, in_pos_x};
  assign fm_raddr = {ch_r, oy[Y_BITS-1:0], ox[X_BITS-1:0]};
  assign sw_we    = (state_r == S_FIN);
  assign sw_addr  = {ch_r, py_r, px_r};

  always_ff @(posedge clk) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= in_sample_value;
    end
    fm_rdata_r <= frame_mem[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sw_we) begin
      switch_mem[sw_addr] <= {by_r, bx_r};
    end
    sw_rdata_r <= switch_mem[sw_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_action == ACT_POOL || in_action == ACT_GRAD)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = in_range ? S_SPAN : S_EMIT;
      S_SPAN: begin
        if (!hits_x || !hits_y) begin
          state_nxt = S_EMIT;
        end else if (act_r == ACT_POOL) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_GRAD;
        end
      end
      S_SCAN: begin
        if (last_fy && last_fx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_EMIT;
      S_GRAD:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_SCAN) && cell_in;
      if (state_r == S_SPAN) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      ch_r   <= in_channel;
      grad_r <= in_sample_value;
    end
    if (state_r == S_CHECK) begin
      x0_r         <= x0_nxt;
      y0_r         <= y0_nxt;
      res_value_r  <= '0;
      res_x_r      <= '0;
      res_y_r      <= '0;
      res_status_r <= ST_RANGE;
    end
    if (state_r == S_SPAN) begin
      fx_r         <= '0;
      fy_r         <= '0;
      res_value_r  <= (act_r == ACT_POOL) ? SAMPLE_MIN : '0;
      res_status_r <= ST_EMPTY;
    end
    if (state_r == S_SCAN) begin
      rd_x_r <= ox[X_BITS-1:0];
      rd_y_r <= oy[Y_BITS-1:0];
      if (last_fy) begin
        fy_r <= '0;
        fx_r <= fx_r + 3'd1;
      end else begin
        fy_r <= fy_r + 3'd1;
      end
    end
    if (take) begin
      best_r <= fm_rdata_r;
      bx_r   <= rd_x_r;
      by_r   <= rd_y_r;
    end
    if (state_r == S_FIN) begin
      res_value_r  <= best_r;
      res_x_r      <= bx_r;
      res_y_r      <= by_r;
      res_status_r <= ST_OK;
    end
    if (state_r == S_GRAD) begin
      res_value_r  <= grad_r;
      res_x_r      <= sw_rdata_r[X_BITS-1:0];
      res_y_r      <= sw_rdata_r[X_BITS+Y_BITS-1:X_BITS];
      res_status_r <= ST_OK;
    end
    if (state_r == S_EMIT && out_free) begin
      out_value_r  <= res_value_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_ch_r     <= ch_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_value_r;
  assign out_winner_x       = out_x_r;
  assign out_winner_y       = out_y_r;
  assign out_result_channel = out_ch_r;
  assign out_status         = out_status_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == S_IDLE && !col_busy && !row_busy))
    else $error("item accepted while busy");

  a_fin_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> found_r)
    else $error("pool finished without an in-frame cell");

  a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r == S_SCAN))
    else $error("frame read outside scan");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_RANGE) |->
      (out_value_r == '0 && out_x_r == '0 && out_y_r == '0))
    else $error("out of range result not zero");

endmodule

/* tb/max_pool_2d_with_argmax_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of max_pool_2d_with_argmax_unit: loads frames, pools windows and
// routes gradients under many register settings, each result checked against an inline predictor
// depends on mpa_pkg and the max_pool_2d_with_argmax_unit rtl
module max_pool_2d_with_argmax_unit_tb;
  import mpa_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [X_BITS-1:0]             wx;
    logic [Y_BITS-1:0]             wy;
    logic [CH_BITS-1:0]            ch;
    status_t                       st;
  } winner_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_action = 2'd0;
  logic [X_BITS-1:0]             in_pos_x = '0;
  logic [Y_BITS-1:0]             in_pos_y = '0;
  logic [CH_BITS-1:0]            in_channel = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_result_value;
  logic [X_BITS-1:0]             out_winner_x;
  logic [Y_BITS-1:0]             out_winner_y;
  logic [CH_BITS-1:0]            out_result_channel;
  logic [1:0]                    out_status;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] frame_mem [DEPTH];
  logic [X_BITS+Y_BITS-1:0]      switch_mem [DEPTH];
  bit                            frame_wr [DEPTH];
  bit                            switch_wr [DEPTH];
  logic [CFG_DATA_BITS-1:0]      cfg_shadow [NUM_REGS];
  int g_ww, g_wh, g_step, g_pad, g_fw, g_fh, g_nch;
  int out_cols, out_rows;

  winner_t winner_q [$];
  bit      idle_on = 1'b1;
  int      fail_count = 0;
  int      results_checked = 0;
  int      items_sent = 0;
  int      settings_used = 0;
  int      act_count [4];

  max_pool_2d_with_argmax_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_channel         (in_channel),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_value   (out_result_value),
    .out_winner_x       (out_winner_x),
    .out_winner_y       (out_winner_y),
    .out_result_channel (out_result_channel),
    .out_status         (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CFG_DATA_BITS-1:0] reg_mask(cfg_reg_t r);
    case (r)
      REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT, REG_STRIDE_STEP: return 7'h0F;
      REG_PAD_AMOUNT: return 7'h07;
      REG_FRAME_CHANNELS: return 7'h1F;
      default: return 7'h7F;
    endcase
  endfunction

  function automatic int eff_win(int raw);
    if (raw == 0) return 1;
    return raw > MAX_WINDOW ? MAX_WINDOW : raw;
  endfunction

  function automatic int clamp_to(int raw, int lim);
    return raw > lim ? lim : raw;
  endfunction

  function automatic int out_dim(int frame, int win, int lim);
    int n;
    n = frame + 2 * g_pad - win + g_step;
    if (n <= 0) return 0;
    n = n / g_step;
    return n > lim ? lim : n;
  endfunction

  function automatic void refresh_geometry();
    g_ww = eff_win(cfg_shadow[REG_WINDOW_WIDTH]);
    g_wh = eff_win(cfg_shadow[REG_WINDOW_HEIGHT]);
    g_step = cfg_shadow[REG_STRIDE_STEP] == 0 ? 1 : int'(cfg_shadow[REG_STRIDE_STEP]);
    g_pad = cfg_shadow[REG_PAD_AMOUNT];
    g_fw = clamp_to(cfg_shadow[REG_FRAME_WIDTH], MAX_FRAME_WIDTH);
    g_fh = clamp_to(cfg_shadow[REG_FRAME_HEIGHT], MAX_FRAME_HEIGHT);
    g_nch = clamp_to(cfg_shadow[REG_FRAME_CHANNELS], MAX_CHANNELS);
    out_cols = out_dim(g_fw, g_ww, MAX_FRAME_WIDTH);
    out_rows = out_dim(g_fh, g_wh, MAX_FRAME_HEIGHT);
  endfunction

  function automatic int store_addr(int ch, int py, int px);
    return (ch * MAX_FRAME_HEIGHT + py) * MAX_FRAME_WIDTH + px;
  endfunction

  function automatic bit in_range(int px, int py, int ch);
    return px < out_cols && py < out_rows && ch < g_nch;
  endfunction

  function automatic bit window_hits(int px, int py);
    int x0, y0;
    x0 = px * g_step - g_pad;
    y0 = py * g_step - g_pad;
    return g_fw > 0 && x0 < g_fw && x0 + g_ww - 1 >= 0 &&
           g_fh > 0 && y0 < g_fh && y0 + g_wh - 1 >= 0;
  endfunction

  // updates the stores and returns 1 when the item yields a result
  function automatic bit compute_winner(action_t act, int px, int py, int ch,
                                        logic signed [SAMPLE_BITS-1:0] val, output winner_t w);
    int addr, best, bx, by, ox, oy, v;
    bit found;
    addr = store_addr(ch, py, px);
    w.value = '0;
    w.wx = '0;
    w.wy = '0;
    w.ch = ch;
    w.st = ST_OK;
    if (act == ACT_LOAD) begin
      frame_mem[addr] = val;
      frame_wr[addr] = 1'b1;
      return 1'b0;
    end
    if (act == ACT_NONE) return 1'b0;
    if (!in_range(px, py, ch)) begin
      w.st = ST_RANGE;
      return 1'b1;
    end
    if (!window_hits(px, py)) begin
      w.st = ST_EMPTY;
      if (act == ACT_POOL) w.value = SAMPLE_MIN;
      return 1'b1;
    end
    if (act == ACT_GRAD) begin
      w.value = val;
      w.wx = switch_mem[addr][X_BITS-1:0];
      w.wy = switch_mem[addr][X_BITS+:Y_BITS];
      return 1'b1;
    end
    found = 1'b0;
    best = 0;
    bx = 0;
    by = 0;
    // columns outer, rows inner, first strictly greater wins
    for (int fx = 0; fx < g_ww; fx++) begin
      ox = px * g_step - g_pad + fx;
      if (ox < 0 || ox >= g_fw) continue;
      for (int fy = 0; fy < g_wh; fy++) begin
        oy = py * g_step - g_pad + fy;
        if (oy < 0 || oy >= g_fh) continue;
        v = frame_mem[store_addr(ch, oy, ox)];
        if (!found || v > best) begin
          found = 1'b1;
          best = v;
          bx = ox;
          by = oy;
        end
      end
    end
    switch_mem[addr] = by * MAX_FRAME_WIDTH + bx;
    switch_wr[addr] = 1'b1;
    w.value = best;
    w.wx = bx;
    w.wy = by;
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MIN;
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2, 3: return $urandom_range(0, 4) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pos(int n, int lim);
    if (n == 0) return $urandom_range(0, lim - 1);
    if ($urandom_range(0, 1)) return $urandom_range(0, (n < 4 ? n : 4) - 1);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic send_item(action_t act, int px, int py, int ch,
                           logic signed [SAMPLE_BITS-1:0] val);
    winner_t w;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pos_x <= px;
    in_pos_y <= py;
    in_channel <= ch;
    in_sample_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (compute_winner(act, px, py, ch, val, w)) winner_q.push_back(w);
    act_count[act]++;
    if (act != ACT_NONE) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (winner_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_shadow[r] = v & reg_mask(r);
    refresh_geometry();
  endtask

  task automatic apply_config(logic [CFG_DATA_BITS-1:0] ww, logic [CFG_DATA_BITS-1:0] wh,
                              logic [CFG_DATA_BITS-1:0] st, logic [CFG_DATA_BITS-1:0] pad,
                              logic [CFG_DATA_BITS-1:0] fw, logic [CFG_DATA_BITS-1:0] fh,
                              logic [CFG_DATA_BITS-1:0] nch);
    wait_idle();
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_STRIDE_STEP, st);
    write_reg(REG_PAD_AMOUNT, pad);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_FRAME_CHANNELS, nch);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // fills unwritten cells of the window before pooling
  task automatic pool_at(int px, int py, int ch);
    int ox, oy;
    if (in_range(px, py, ch) && window_hits(px, py)) begin
      for (int fx = 0; fx < g_ww; fx++) begin
        for (int fy = 0; fy < g_wh; fy++) begin
          ox = px * g_step - g_pad + fx;
          oy = py * g_step - g_pad + fy;
          if (ox >= 0 && ox < g_fw && oy >= 0 && oy < g_fh && !frame_wr[store_addr(ch, oy, ox)])
            send_item(ACT_LOAD, ox, oy, ch, pick_sample());
        end
      end
    end
    send_item(ACT_POOL, px, py, ch, pick_sample());
  endtask

  task automatic grad_at(int px, int py, int ch);
    if (in_range(px, py, ch) && window_hits(px, py) && !switch_wr[store_addr(ch, py, px)])
      pool_at(px, py, ch);
    send_item(ACT_GRAD, px, py, ch, pick_sample());
  endtask

  task automatic run_mixed(int budget);
    int stop_at, pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        pool_at(pick_pos(out_cols, MAX_FRAME_WIDTH), pick_pos(out_rows, MAX_FRAME_HEIGHT),
                pick_pos(g_nch, MAX_CHANNELS));
      else if (pick < 75)
        grad_at(pick_pos(out_cols, MAX_FRAME_WIDTH), pick_pos(out_rows, MAX_FRAME_HEIGHT),
                pick_pos(g_nch, MAX_CHANNELS));
      else if (pick < 87)
        send_item(ACT_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 15), pick_sample());
      else if (pick < 91)
        pool_at($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15));
      else if (pick < 95)
        grad_at($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15));
      else if (pick < 99)
        send_item(ACT_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 15), pick_sample());
      else
        wait_idle();
    end
  endtask

  task automatic test_after_reset();
    // sizes stay zero until the first register write
    send_item(ACT_POOL, 0, 0, 0, 0);
    send_item(ACT_GRAD, 0, 0, 0, 16'sh7FFF);
    send_item(ACT_NONE, 63, 63, 15, SAMPLE_MIN);
  endtask

  task automatic test_ties_and_borders();
    apply_config(2, 2, 2, 1, 3, 3, 1);
    send_item(ACT_LOAD, 1, 1, 0, 7);
    send_item(ACT_LOAD, 1, 2, 0, 16'sh7FFF);
    send_item(ACT_LOAD, 2, 1, 0, 16'sh7FFF);
    send_item(ACT_LOAD, 2, 2, 0, -1);
    send_item(ACT_POOL, 1, 1, 0, 0);
    send_item(ACT_GRAD, 1, 1, 0, SAMPLE_MIN);
    // stale switch after the winning sample is overwritten
    send_item(ACT_LOAD, 1, 2, 0, SAMPLE_MIN);
    send_item(ACT_GRAD, 1, 1, 0, 1);
    send_item(ACT_LOAD, 0, 0, 0, SAMPLE_MIN);
    send_item(ACT_POOL, 0, 0, 0, 16'sh5555);
    send_item(ACT_GRAD, 0, 0, 0, 16'sh7FFF);
    send_item(ACT_POOL, 2, 0, 0, 0);
    send_item(ACT_GRAD, 0, 0, 15, 0);
    send_item(ACT_LOAD, 63, 63, 15, 16'shAAAA);
    send_item(ACT_POOL, 63, 63, 15, 0);
  endtask

  task automatic test_empty_window();
    apply_config(1, 1, 1, 7, 4, 4, 2);
    send_item(ACT_POOL, 0, 0, 1, 0);
    send_item(ACT_GRAD, 0, 0, 1, 16'sh1234);
    send_item(ACT_POOL, 7, 7, 0, 0);
  endtask

  task automatic test_extreme_settings();
    apply_config(8, 8, 1, 7, 64, 64, 16);
    run_mixed(60);
    apply_config(1, 1, 1, 0, 1, 1, 1);
    run_mixed(60);
    // zero window and stride, over-range sizes, zero frame width
    apply_config(0, 7'h7F, 0, 3, 0, 7'h7F, 7'h7F);
    run_mixed(60);
    apply_config(3, 5, 8, 2, 20, 9, 0);
    run_mixed(40);
    apply_config(8, 8, 8, 0, 7'h7F, 7'h40, 4);
    run_mixed(80);
    apply_config(7, 2, 3, 7, 5, 2, 3);
    run_mixed(60);
  endtask

  task automatic test_random_settings();
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 3) == 0)
        apply_config($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 127));
      else
        apply_config($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                     $urandom_range(0, 7), $urandom_range(1, 16), $urandom_range(1, 16),
                     $urandom_range(1, 4));
      idle_on = (i != 2);
      run_mixed(140);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle_tail();
    idle_on = 1'b0;
    apply_config(2, 3, 2, 1, 12, 10, 3);
    run_mixed(120);
    apply_config(4, 4, 3, 2, 16, 16, 2);
    run_mixed(120);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 19) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_results
    winner_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (winner_q.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d at (%0d,%0d) ch %0d status %0d",
                               out_result_value, out_winner_x, out_winner_y,
                               out_result_channel, out_status));
      end else begin
        want = winner_q.pop_front();
        if (out_result_value !== want.value || out_winner_x !== want.wx ||
            out_winner_y !== want.wy || out_result_channel !== want.ch ||
            out_status !== want.st)
          note_failure($sformatf({"result %0d: expected value %0d at (%0d,%0d) ch %0d status %0d,",
                                  " got value %0d at (%0d,%0d) ch %0d status %0d"},
                                 results_checked, want.value, want.wx, want.wy, want.ch,
                                 want.st, out_result_value, out_winner_x, out_winner_y,
                                 out_result_channel, out_status));
        results_checked++;
      end
    end
  end

  initial begin
    cfg_shadow[REG_WINDOW_WIDTH] = 2;
    cfg_shadow[REG_WINDOW_HEIGHT] = 2;
    cfg_shadow[REG_STRIDE_STEP] = 2;
    cfg_shadow[REG_PAD_AMOUNT] = 0;
    cfg_shadow[REG_FRAME_WIDTH] = 64;
    cfg_shadow[REG_FRAME_HEIGHT] = 64;
    cfg_shadow[REG_FRAME_CHANNELS] = 16;
    refresh_geometry();
    out_cols = 0;
    out_rows = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_ties_and_borders();
    test_empty_window();
    test_extreme_settings();
    test_random_settings();
    test_no_idle_tail();
    wait_idle();
    $display("covered %0d loads, %0d pools, %0d gradients and %0d unused-action items",
             act_count[ACT_LOAD], act_count[ACT_POOL], act_count[ACT_GRAD], act_count[ACT_NONE]);
    $display("%0d results checked over %0d register settings, %0d failures",
             results_checked, settings_used, fail_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
